[design/lis_pkg.sv]
package lis_pkg;

  // table capacity and derived widths
  localparam int unsigned MAX_LENGTH = 1024;
  localparam int unsigned ADDR_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_LENGTH + 1);
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned LEN_W      = 11;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_e;

  // memory access from the controller
  typedef struct packed {
    logic               re;
    logic               we;
    addr_t              raddr;
    addr_t              waddr;
    logic [VALUE_W-1:0] wdata;
  } mem_req_t;

  // result word handed to the output register
  typedef struct packed {
    logic             load;
    logic [LEN_W-1:0] lis_length;
    logic             is_final;
    logic             overflow;
  } res_t;

  // midpoint of a search window
  function automatic cnt_t mid_of(cnt_t lo, cnt_t hi);
    cnt_t span;
    span = hi - lo;
    return lo + (span >> 1);
  endfunction

endpackage

[design/lis_if.sv]
interface lis_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       value;
  logic                     last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface lis_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] lis_length;
  logic        is_final;
  logic        overflow;

  modport source (output valid, output lis_length, output is_final, output overflow,
                  input ready);
  modport sink   (input valid, input lis_length, input is_final, input overflow,
                  output ready);
endinterface

[design/lis_ram.sv]
module lis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/lis_ctrl.sv]
module lis_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  lis_in_if.sink            in_if,
  input  logic [31:0]       rdata_i,
  input  logic              out_free_i,
  output lis_pkg::mem_req_t mem_o,
  output lis_pkg::res_t     res_o
);
  import lis_pkg::*;

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  logic   ovf_q, ovf_d;
  cnt_t   lo_q, lo_d;
  cnt_t   hi_q, hi_d;
  cnt_t   mid_q, mid_d;
  logic signed [VALUE_W-1:0] value_q;
  logic   last_q;

  logic   accept;
  cnt_t   lo_n, hi_n;
  logic   search_go;
  cnt_t   count_upd;
  logic   ovf_upd;

  assign accept = in_if.valid && in_if.ready;

  // narrow the window with the tail just read
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if ($signed(rdata_i) < value_q) begin
      lo_n = mid_q + cnt_t'(1);
    end else begin
      hi_n = mid_q;
    end
  end

  assign search_go = (lo_n < hi_n);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (count_q == '0) ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        state_d = search_go ? S_SEARCH : S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, memory requests and result
  always_comb begin
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    count_upd = count_q;
    ovf_upd   = ovf_q;
    mem_o     = '0;
    res_o     = '0;
    in_if.ready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          lo_d      = '0;
          hi_d      = count_q;
          mid_d     = mid_of('0, count_q);
          mem_o.re  = (count_q != '0);
        end
      end
      S_SEARCH: begin
        lo_d     = lo_n;
        hi_d     = hi_n;
        mid_d    = mid_of(lo_n, hi_n);
        mem_o.re = search_go;
      end
      S_DONE: begin
        // overwrite, append or drop at the found position
        if (lo_q < count_q) begin
          mem_o.we = out_free_i;
        end else if (count_q < cnt_t'(MAX_LENGTH)) begin
          mem_o.we  = out_free_i;
          count_upd = count_q + cnt_t'(1);
        end else begin
          ovf_upd = 1'b1;
        end
        res_o.load       = out_free_i;
        res_o.lis_length = LEN_W'(count_upd);
        res_o.is_final   = last_q;
        res_o.overflow   = ovf_upd;
        if (out_free_i) begin
          count_d = last_q ? '0 : count_upd;
          ovf_d   = last_q ? 1'b0 : ovf_upd;
        end
      end
      default: ;
    endcase

    mem_o.raddr = addr_t'(mid_d);
    mem_o.waddr = addr_t'(lo_q);
    mem_o.wdata = value_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // search window and held word
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    if (accept) begin
      value_q <= in_if.value;
      last_q  <= in_if.last_item;
    end
  end

endmodule

[design/longest_increasing_subsequence_length.sv]
// channel  dir  handshake     payload
// in_if    in   valid/ready   value[31:0] signed, last_item
// out_if   out  valid/ready   lis_length[10:0], is_final, overflow
//
// a word is taken while idle, then p probes of a binary search over the tail
// table, at most ceil(log2(count+1)), find its place; write-back follows.
// each probe is one read of the single tail RAM, compared as it returns.
// a new word is taken only while no search is running; a result waiting in
// the output register stalls the write-back step until it is taken.
// reset clears count, overflow flag and valid; the table needs no clearing.
module longest_increasing_subsequence_length (
  input  logic      clk_i,
  input  logic      rst_ni,
  lis_in_if.sink    in_if,
  lis_out_if.source out_if
);
  import lis_pkg::*;

  mem_req_t           mem_req;
  res_t               res;
  logic [VALUE_W-1:0] rdata;
  logic               out_free;
  logic               out_valid_q;
  logic [LEN_W-1:0]   len_q;
  logic               final_q;
  logic               ovf_q;

  assign out_free = !out_valid_q || out_if.ready;

  lis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .rdata_i    (rdata),
    .out_free_i (out_free),
    .mem_o      (mem_req),
    .res_o      (res)
  );

  lis_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LENGTH)
  ) u_tails (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res.load) begin
      len_q   <= res.lis_length;
      final_q <= res.is_final;
      ovf_q   <= res.overflow;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.lis_length = len_q;
  assign out_if.is_final   = final_q;
  assign out_if.overflow   = ovf_q;

endmodule
